// ----- hw/rtl/lwb_pkg.sv -----
// Shared types and constants for the Lax-Wendroff Burgers stencil.
// No dependencies; imported by the top level, lwb_mul, lwb_dp and lwb_ctrl.
package lwb_pkg;

    localparam int WORD_W    = 32;
    localparam int COURANT_W = 17;
    localparam int STEPS_W   = 16;
    localparam int SQ_W      = 48;
    localparam int WIDE_W    = 64;
    localparam int AA_W      = 34;

    localparam logic [COURANT_W-1:0] COURANT_RESET = 17'd32768;
    localparam logic [STEPS_W-1:0]   STEPS_RESET   = 16'd1;

    // configuration register indexes
    localparam logic CFG_COURANT = 1'b0;
    localparam logic CFG_STEPS   = 1'b1;

    // request operation codes
    localparam logic OPER_LOAD = 1'b0;
    localparam logic OPER_READ = 1'b1;

    // products of one point update, in issue order
    typedef enum logic [2:0] {
        OP_QM, OP_Q, OP_QP, OP_T1, OP_CP, OP_CM, OP_T2
    } t_op;

    // rounding shift of the shared multiplier
    typedef enum logic [1:0] {
        SH_16, SH_18, SH_35
    } t_shift;

    // controller to datapath
    typedef struct packed {
        logic take;     // input request accepted
        logic fetch;    // read source bank at fetch address
        logic cap_m;    // capture left neighbor
        logic cap_c;    // capture center
        logic cap_p;    // capture right neighbor
        logic op_go;    // start one product
        t_op  op;
        logic wr_copy;  // write center unchanged (end point)
        logic wr_upd;   // write updated center
        logic flip;     // swap banks at end of a time step
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic               out_room;
        logic               run_req;
        logic               op_done;
        logic [STEPS_W-1:0] steps;
    } t_stat;

endpackage

// ----- hw/rtl/lwb_in_if.sv -----
// Input request channel: valid/ready with load/read payload.
// No dependencies.
interface lwb_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [31:0] sample;
    logic        final_sample;

    modport source (output valid, output operation, output sample, output final_sample,
                    input ready);
    modport sink   (input valid, input operation, input sample, input final_sample,
                    output ready);
endinterface

// ----- hw/rtl/lwb_out_if.sv -----
// Result channel: valid/ready with grid value and end flag.
// No dependencies.
interface lwb_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;
    logic        end_of_grid;

    modport source (output valid, output value, output end_of_grid, input ready);
    modport sink   (input valid, input value, input end_of_grid, output ready);
endinterface

// ----- hw/rtl/lax_wendroff_burgers_stencil.sv -----
// Top level of the Lax-Wendroff Burgers stencil: controller plus datapath.
// Uses lwb_pkg, lwb_in_if, lwb_out_if, lwb_ctrl and lwb_dp.
// Loads and reads are taken one per cycle while idle with room in the result queue; a read
// result is valid once the bank read and the pending flag have passed it into the queue.
// A final load with a nonzero step count and grid size holds ready low for step_count passes;
// every point is read via the single bank read port and each interior point takes seven products.
// Synchronous active-low reset clears indices, bank select and queue; grid contents stay.
module lax_wendroff_burgers_stencil
    import lwb_pkg::*;
#(
    parameter int MAX_POINTS = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    lwb_in_if.sink               i_in,
    lwb_out_if.source            o_out,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [COURANT_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    t_cmd          cmd;
    t_stat         stat;
    logic [CW-1:0] count;
    logic [AW-1:0] fetch_addr, point;

    lwb_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .o_in_ready   (i_in.ready),
        .i_stat       (stat),
        .i_count      (count),
        .o_cmd        (cmd),
        .o_fetch_addr (fetch_addr),
        .o_point      (point)
    );

    lwb_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_operation    (i_in.operation),
        .i_sample       (i_in.sample),
        .i_final_sample (i_in.final_sample),
        .i_cmd          (cmd),
        .i_fetch_addr   (fetch_addr),
        .i_point        (point),
        .o_stat         (stat),
        .o_count        (count),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_value        (o_out.value),
        .o_end_of_grid  (o_out.end_of_grid)
    );

endmodule

// ----- hw/rtl/lwb_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module lwb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/lwb_mul.sv -----
// Shared multi-cycle signed multiplier with round-half-away and saturation.
// Uses lwb_pkg. 64x64 magnitudes as four 32x32 partial products.
module lwb_mul
    import lwb_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [WIDE_W-1:0] i_x,
    input  logic signed [WIDE_W-1:0] i_y,
    input  t_shift                   i_shift,
    output logic                     o_done,
    output logic signed [WIDE_W-1:0] o_res
);

    typedef enum logic [4:0] {
        M_IDLE = 5'b00001,
        M_ABS  = 5'b00010,
        M_PP   = 5'b00100,
        M_RND  = 5'b01000,
        M_OUT  = 5'b10000
    } t_mstate;

    t_mstate r_state;
    logic signed [WIDE_W-1:0] r_x, r_y, r_res;
    t_shift        r_sh;
    logic [63:0]   r_a, r_b;
    logic          r_neg, r_done;
    logic [1:0]    r_k;
    logic [127:0]  r_acc;
    logic [61:0]   r_mag;

    logic [31:0]   pa, pb;
    logic [63:0]   prod;
    logic [127:0]  pp_shift, half, rsum, rshift;

    // partial product select and alignment
    always_comb begin
        pa   = r_k[1] ? r_a[63:32] : r_a[31:0];
        pb   = r_k[0] ? r_b[63:32] : r_b[31:0];
        prod = pa * pb;
        case (r_k)
            2'd0:    pp_shift = 128'(prod);
            2'd3:    pp_shift = 128'(prod) << 64;
            default: pp_shift = 128'(prod) << 32;
        endcase
    end

    // rounding offset and shift
    always_comb begin
        case (r_sh)
            SH_16:   half = 128'(1) << 15;
            SH_18:   half = 128'(1) << 17;
            SH_35:   half = 128'(1) << 34;
            default: half = '0;
        endcase
        rsum = r_acc + half;
        case (r_sh)
            SH_16:   rshift = rsum >> 16;
            SH_18:   rshift = rsum >> 18;
            SH_35:   rshift = rsum >> 35;
            default: rshift = rsum;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                M_IDLE: begin
                    if (i_start) begin
                        r_state <= M_ABS;
                    end
                end
                M_ABS:   r_state <= M_PP;
                M_PP: begin
                    if (r_k == 2'd3) begin
                        r_state <= M_RND;
                    end
                end
                M_RND:   r_state <= M_OUT;
                M_OUT: begin
                    r_done  <= 1'b1;
                    r_state <= M_IDLE;
                end
                default: r_state <= M_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == M_IDLE && i_start) begin
            r_x  <= i_x;
            r_y  <= i_y;
            r_sh <= i_shift;
        end
        if (r_state == M_ABS) begin
            r_a   <= r_x[WIDE_W-1] ? 64'(-r_x) : 64'(r_x);
            r_b   <= r_y[WIDE_W-1] ? 64'(-r_y) : 64'(r_y);
            r_neg <= r_x[WIDE_W-1] ^ r_y[WIDE_W-1];
            r_k   <= 2'd0;
            r_acc <= '0;
        end
        if (r_state == M_PP) begin
            r_acc <= r_acc + pp_shift;
            r_k   <= r_k + 2'd1;
        end
        if (r_state == M_RND) begin
            r_mag <= (|rshift[127:62]) ? {62{1'b1}} : rshift[61:0];
        end
        if (r_state == M_OUT) begin
            r_res <= r_neg ? -$signed(64'(r_mag)) : $signed(64'(r_mag));
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ----- hw/rtl/lwb_dp.sv -----
// Datapath: grid banks, config registers, neighbor window, products, result queue.
// Uses lwb_pkg, lwb_ram and lwb_mul.
module lwb_dp
    import lwb_pkg::*;
#(
    parameter int MAX_POINTS = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_operation,
    input  logic [WORD_W-1:0]                 i_sample,
    input  logic                              i_final_sample,
    input  t_cmd                              i_cmd,
    input  logic [$clog2(MAX_POINTS)-1:0]     i_fetch_addr,
    input  logic [$clog2(MAX_POINTS)-1:0]     i_point,
    output t_stat                             o_stat,
    output logic [$clog2(MAX_POINTS+1)-1:0]   o_count,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_idx,
    input  logic [COURANT_W-1:0]              i_cfg_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [WORD_W-1:0]                 o_value,
    output logic                              o_end_of_grid
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    logic [COURANT_W-1:0] r_courant;
    logic [STEPS_W-1:0]   r_steps;
    logic [AA_W-1:0]      r_aa;
    logic [CW-1:0]        r_count, r_load_idx;
    logic [AW-1:0]        r_rd_idx;
    logic                 r_cur, r_pend, r_plast;
    logic [1:0]           r_cnt;
    logic                 r_wp, r_rp;
    logic [WORD_W-1:0]    r_fval [2];
    logic                 r_flast [2];
    logic signed [WORD_W-1:0] r_wm, r_wc, r_wp_val;
    logic signed [SQ_W-1:0]   r_qm, r_q, r_qp;
    logic signed [WIDE_W-1:0] r_t1, r_cp, r_cm, r_t2;
    t_op                  r_op;

    logic                 load_ok, take_load, take_read, pop, push;
    logic [CW-1:0]        count_next;
    logic [AW-1:0]        rd_eff, raddr, waddr;
    logic                 rd_last;
    logic [WORD_W-1:0]    rdata_e, rdata_o, rdata, upd_val, wdata;
    logic                 we_comp, we_e, we_o;
    logic signed [WIDE_W-1:0] mx, my, mres;
    t_shift               msh;
    logic                 mdone;
    logic signed [WIDE_W+1:0] usum;

    // request decode
    assign load_ok    = r_load_idx < CW'(MAX_POINTS);
    assign take_load  = i_cmd.take && i_operation == OPER_LOAD;
    assign take_read  = i_cmd.take && i_operation == OPER_READ;
    assign count_next = load_ok ? r_load_idx + CW'(1) : r_load_idx;
    assign rd_eff     = (CW'(r_rd_idx) >= r_count) ? '0 : r_rd_idx;
    assign rd_last    = (CW'(rd_eff) + CW'(1)) == r_count;

    // result queue accounting
    assign pop  = o_out_valid && i_out_ready;
    assign push = r_pend;

    always_comb begin
        o_stat.out_room = ({1'b0, r_cnt} + {2'b0, r_pend} - {2'b0, pop}) < 3'd2;
        o_stat.run_req  = i_operation == OPER_LOAD && i_final_sample
                          && count_next != '0 && r_steps != '0;
        o_stat.op_done  = mdone;
        o_stat.steps    = r_steps;
    end
    assign o_count = r_count;

    // updated center value, saturated to Q16.16
    always_comb begin
        usum = (WIDE_W+2)'(r_wc) - (WIDE_W+2)'(r_t1) + (WIDE_W+2)'(r_t2);
        if (usum > (WIDE_W+2)'(32'sh7fffffff)) begin
            upd_val = 32'h7fffffff;
        end else if (usum < -(WIDE_W+2)'(33'sh080000000)) begin
            upd_val = 32'h80000000;
        end else begin
            upd_val = usum[WORD_W-1:0];
        end
    end

    // bank port muxing: loads write the current bank, steps write the other
    assign we_comp = i_cmd.wr_copy || i_cmd.wr_upd;
    assign waddr   = take_load ? r_load_idx[AW-1:0] : i_point;
    assign wdata   = take_load ? i_sample : (i_cmd.wr_copy ? r_wc : upd_val);
    assign we_e    = (take_load && load_ok && !r_cur) || (we_comp && r_cur);
    assign we_o    = (take_load && load_ok && r_cur) || (we_comp && !r_cur);
    assign raddr   = i_cmd.fetch ? i_fetch_addr : rd_eff;
    assign rdata   = r_cur ? rdata_o : rdata_e;

    lwb_ram #(.WIDTH(WORD_W), .DEPTH(MAX_POINTS)) u_bank_even (
        .i_clk   (i_clk),
        .i_we    (we_e),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata_e)
    );

    lwb_ram #(.WIDTH(WORD_W), .DEPTH(MAX_POINTS)) u_bank_odd (
        .i_clk   (i_clk),
        .i_we    (we_o),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata_o)
    );

    // operand select for the shared multiplier
    always_comb begin
        case (i_cmd.op)
            OP_QM: begin
                mx = WIDE_W'(r_wm); my = WIDE_W'(r_wm); msh = SH_16;
            end
            OP_Q: begin
                mx = WIDE_W'(r_wc); my = WIDE_W'(r_wc); msh = SH_16;
            end
            OP_QP: begin
                mx = WIDE_W'(r_wp_val); my = WIDE_W'(r_wp_val); msh = SH_16;
            end
            OP_T1: begin
                mx  = WIDE_W'(r_qp) - WIDE_W'(r_qm);
                my  = $signed({{(WIDE_W-COURANT_W){1'b0}}, r_courant});
                msh = SH_18;
            end
            OP_CP: begin
                mx  = WIDE_W'(r_wp_val) + WIDE_W'(r_wc);
                my  = WIDE_W'(r_qp) - WIDE_W'(r_q);
                msh = SH_16;
            end
            OP_CM: begin
                mx  = WIDE_W'(r_wc) + WIDE_W'(r_wm);
                my  = WIDE_W'(r_q) - WIDE_W'(r_qm);
                msh = SH_16;
            end
            OP_T2: begin
                mx  = r_cp - r_cm;
                my  = $signed({{(WIDE_W-AA_W){1'b0}}, r_aa});
                msh = SH_35;
            end
            default: begin
                mx = '0; my = '0; msh = SH_16;
            end
        endcase
    end

    lwb_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op_go),
        .i_x     (mx),
        .i_y     (my),
        .i_shift (msh),
        .o_done  (mdone),
        .o_res   (mres)
    );

    // control state: config, indices, bank select, queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_courant  <= COURANT_RESET;
            r_steps    <= STEPS_RESET;
            r_count    <= '0;
            r_load_idx <= '0;
            r_rd_idx   <= '0;
            r_cur      <= 1'b0;
            r_pend     <= 1'b0;
            r_cnt      <= '0;
            r_wp       <= 1'b0;
            r_rp       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_COURANT: r_courant <= i_cfg_data;
                    CFG_STEPS:   r_steps   <= i_cfg_data[STEPS_W-1:0];
                endcase
            end
            if (take_load) begin
                if (i_final_sample) begin
                    r_count    <= count_next;
                    r_load_idx <= '0;
                    r_rd_idx   <= '0;
                end else begin
                    r_load_idx <= count_next;
                end
            end
            r_pend <= take_read && r_count != '0;
            if (take_read && r_count != '0) begin
                r_rd_idx <= rd_last ? '0 : rd_eff + AW'(1);
            end
            if (i_cmd.flip) begin
                r_cur <= ~r_cur;
            end
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_aa <= r_courant * r_courant;
        if (take_read) begin
            r_plast <= rd_last;
        end
        if (push) begin
            r_fval[r_wp]  <= rdata;
            r_flast[r_wp] <= r_plast;
        end
        if (i_cmd.cap_m) r_wm     <= rdata;
        if (i_cmd.cap_c) r_wc     <= rdata;
        if (i_cmd.cap_p) r_wp_val <= rdata;
        if (i_cmd.op_go) begin
            r_op <= i_cmd.op;
        end
        if (mdone) begin
            case (r_op)
                OP_QM:   r_qm <= mres[SQ_W-1:0];
                OP_Q:    r_q  <= mres[SQ_W-1:0];
                OP_QP:   r_qp <= mres[SQ_W-1:0];
                OP_T1:   r_t1 <= mres;
                OP_CP:   r_cp <= mres;
                OP_CM:   r_cm <= mres;
                OP_T2:   r_t2 <= mres;
                default: r_t2 <= mres;
            endcase
        end
    end

    assign o_out_valid   = r_cnt != '0;
    assign o_value       = r_fval[r_rp];
    assign o_end_of_grid = r_flast[r_rp];

    // queue never takes a read result while full unless one leaves
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && r_cnt == 2'd2) |-> pop)
        else $error("result queue overflow");

    // a load and a step write never share the bank write ports
    a_write_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take_load |-> !we_comp)
        else $error("load collides with step write");

endmodule

// ----- hw/rtl/lwb_ctrl.sv -----
// Controller: request acceptance and the time-step / point / product sequence.
// Uses lwb_pkg.
module lwb_ctrl
    import lwb_pkg::*;
#(
    parameter int MAX_POINTS = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  t_stat                           i_stat,
    input  logic [$clog2(MAX_POINTS+1)-1:0] i_count,
    output t_cmd                            o_cmd,
    output logic [$clog2(MAX_POINTS)-1:0]   o_fetch_addr,
    output logic [$clog2(MAX_POINTS)-1:0]   o_point
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b00000001,
        S_RD0    = 8'b00000010,
        S_RD1    = 8'b00000100,
        S_RD2    = 8'b00001000,
        S_RD3    = 8'b00010000,
        S_OPGO   = 8'b00100000,
        S_OPWAIT = 8'b01000000,
        S_WR     = 8'b10000000
    } t_state;

    t_state             r_state;
    logic [AW-1:0]      r_i;
    logic [STEPS_W-1:0] r_t;
    t_op                r_op;
    logic               first_pt, last_pt, end_pt, last_step;

    assign first_pt  = r_i == '0;
    assign last_pt   = (CW'(r_i) + CW'(1)) == i_count;
    assign end_pt    = first_pt || last_pt;
    assign last_step = (r_t + STEPS_W'(1)) == i_stat.steps;

    assign o_in_ready = (r_state == S_IDLE) && i_stat.out_room;
    assign o_point    = r_i;

    // commands per state
    always_comb begin
        o_cmd         = '0;
        o_cmd.take    = o_in_ready && i_in_valid;
        o_cmd.fetch   = r_state == S_RD0 || r_state == S_RD1 || r_state == S_RD2;
        o_cmd.cap_m   = r_state == S_RD1;
        o_cmd.cap_c   = r_state == S_RD2;
        o_cmd.cap_p   = r_state == S_RD3;
        o_cmd.op_go   = r_state == S_OPGO;
        o_cmd.op      = r_op;
        o_cmd.wr_copy = r_state == S_WR && end_pt;
        o_cmd.wr_upd  = r_state == S_WR && !end_pt;
        o_cmd.flip    = r_state == S_WR && last_pt;
        case (r_state)
            S_RD0:   o_fetch_addr = first_pt ? r_i : r_i - AW'(1);
            S_RD2:   o_fetch_addr = last_pt ? r_i : r_i + AW'(1);
            default: o_fetch_addr = r_i;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_t     <= '0;
            r_op    <= OP_QM;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd.take && i_stat.run_req) begin
                        r_i     <= '0;
                        r_t     <= '0;
                        r_state <= S_RD0;
                    end
                end
                S_RD0: r_state <= S_RD1;
                S_RD1: r_state <= S_RD2;
                S_RD2: r_state <= S_RD3;
                S_RD3: begin
                    r_op    <= OP_QM;
                    r_state <= end_pt ? S_WR : S_OPGO;
                end
                S_OPGO: r_state <= S_OPWAIT;
                S_OPWAIT: begin
                    if (i_stat.op_done) begin
                        if (r_op == OP_T2) begin
                            r_state <= S_WR;
                        end else begin
                            r_op    <= t_op'(r_op + 3'd1);
                            r_state <= S_OPGO;
                        end
                    end
                end
                S_WR: begin
                    if (last_pt) begin
                        r_i <= '0;
                        if (last_step) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_t     <= r_t + STEPS_W'(1);
                            r_state <= S_RD0;
                        end
                    end else begin
                        r_i     <= r_i + AW'(1);
                        r_state <= S_RD0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // a product never completes in the cycle right after it is issued
    a_mul_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OPGO) |=> !i_stat.op_done)
        else $error("multiplier done too early");

    // last write of the last step returns to idle
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR && last_pt && last_step) |=> (r_state == S_IDLE))
        else $error("run did not end after last step");

endmodule
